>>> rtl/core/sfp_pkg.sv
package sfp_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 36;
  localparam int unsigned MAX_PAYLOAD_DEF = 20;
  localparam int unsigned HEAD_BYTES      = 16;

  localparam logic [7:0]  SYNC_HI  = 8'hA5;
  localparam logic [7:0]  SYNC_LO  = 8'h5A;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Input commands.
  localparam logic [1:0] CMD_BYTE     = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_OVERFLOW = 2'd2;

  // Result event codes.
  localparam logic [2:0] EV_PAYLOAD  = 3'd0;
  localparam logic [2:0] EV_BAD_TYPE = 3'd1;
  localparam logic [2:0] EV_BAD_LEN  = 3'd2;
  localparam logic [2:0] EV_CRC_ERR  = 3'd3;
  localparam logic [2:0] EV_TIMEOUT  = 3'd4;
  localparam logic [2:0] EV_OVERFLOW = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_VERSION = 3'd0;
  localparam logic [2:0] CFG_TYPE_A  = 3'd1;
  localparam logic [2:0] CFG_TYPE_B  = 3'd2;
  localparam logic [2:0] CFG_LEN_A   = 3'd3;
  localparam logic [2:0] CFG_LEN_B   = 3'd4;
  localparam logic [2:0] CFG_TIMEOUT = 3'd5;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CRC    = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_MOVE   = 7'b0001000,
    ST_EMIT   = 7'b0010000,
    ST_PAYRD  = 7'b0100000,
    ST_PAYOUT = 7'b1000000
  } state_e;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int n = 0; n < 8; n++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/sfp_ram.sv
module sfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 36
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/sync_frame_parser_crc16.sv
// Channel    Direction  Payload
// s_axis     in         tdata: data_byte; tuser: command
// m_axis     out        tdata: frame_kind, payload_byte, payload_index, resynced; tuser: event_kind;
//                       tlast: last
// cfg        in         write enable, register index, 16-bit data
//
// A received byte that does not complete a header or frame is handled in the idle state, and so is a
// tick that does not time out; a timeout or an overflow notice then passes to ST_EMIT for the result.
// Completing a frame streams it through the single RAM read port for the CRC and then gives each
// payload byte through a read state and an output state. An error runs a scan over the stored
// bytes, possibly a compaction copy of the kept bytes, then gives the result. Reset is
// asynchronous and clears the control state; the frame store itself is not cleared. A stalled
// result holds in the output register and the sequencer waits for it.
module sync_frame_parser_crc16 #(
  parameter int unsigned FRAME_BYTES = sfp_pkg::FRAME_BYTES_DEF,
  parameter int unsigned MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] frame_kind, [15:8] payload_byte, [20:16] payload_index, [21] resynced, rest zero
  output logic [23:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o,   // [2:0] event_kind
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  import sfp_pkg::*;

  localparam int unsigned FW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned SW = $clog2(FRAME_BYTES + 6);
  localparam int unsigned KW = $clog2(MAX_PAYLOAD);

  // Configuration registers.
  logic [7:0]  cfg_ver_q, cfg_ta_q, cfg_tb_q;
  logic [4:0]  cfg_la_q, cfg_lb_q;
  logic [15:0] cfg_to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ver_q <= 8'd1;
      cfg_ta_q  <= 8'd1;
      cfg_tb_q  <= 8'd2;
      cfg_la_q  <= 5'd12;
      cfg_lb_q  <= 5'd20;
      cfg_to_q  <= 16'd50000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VERSION: cfg_ver_q <= cfg_data_i[7:0];
        CFG_TYPE_A:  cfg_ta_q  <= cfg_data_i[7:0];
        CFG_TYPE_B:  cfg_tb_q  <= cfg_data_i[7:0];
        CFG_LEN_A:   cfg_la_q  <= cfg_data_i[4:0];
        CFG_LEN_B:   cfg_lb_q  <= cfg_data_i[4:0];
        CFG_TIMEOUT: cfg_to_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Payload length of a type code, or zero when the type is unknown or unusable.
  function automatic logic [4:0] kind_len(input logic [7:0] t);
    logic [4:0] len;
    len = 5'd0;
    if (t == cfg_ta_q) begin
      len = cfg_la_q;
    end else if (t == cfg_tb_q) begin
      len = cfg_lb_q;
    end
    if (len == 5'd0 || 32'(len) > MAX_PAYLOAD || HEAD_BYTES + 32'(len) > FRAME_BYTES) begin
      len = 5'd0;
    end
    return len;
  endfunction

  function automatic logic hdr_ok(input logic [7:0] ver, input logic [7:0] typ,
                                  input logic [7:0] lo, input logic [7:0] hi);
    logic [4:0] kl;
    kl = kind_len(typ);
    return ver == cfg_ver_q && kl != 5'd0 && {hi, lo} == {11'd0, kl};
  endfunction

  // Frame store.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  sfp_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  state_e        state_q, state_d;
  logic [FW-1:0] fill_q, fill_d, exp_q, exp_d;
  logic [15:0]   idle_q, idle_d;
  // Shadow copies of header bytes two to four; byte five is checked as it arrives.
  logic [7:0]    ver_q, ver_d, typ_q, typ_d, lo_q, lo_d;
  logic [15:0]   crc_q, crc_d;
  logic [7:0]    crclo_q, crclo_d;
  logic [SW-1:0] ra_q, ra_d, da_q, da_d, src_q, src_d;
  logic          dv_q, dv_d;
  logic [7:0]    win_q [5];
  logic [7:0]    win_d [5];
  logic [7:0]    lastb_q, lastb_d;
  logic [KW-1:0] k_q, k_d;
  logic [2:0]    ev_q, ev_d;
  logic [7:0]    evk_q, evk_d;

  // Output register.
  logic        ov_q;
  logic [2:0]  oev_q;
  logic [7:0]  okind_q, obyte_q;
  logic [4:0]  oidx_q;
  logic        ors_q, olast_q;
  logic        out_free, out_ld;
  logic [2:0]  oev_d;
  logic [7:0]  okind_d, obyte_d;
  logic [4:0]  oidx_d;
  logic        ors_d, olast_d;

  assign out_free = !ov_q || m_axis_tready_i;

  logic          in_acc;
  logic [FW-1:0] fill_n, plen;
  logic [4:0]    kl_n;
  logic [7:0]    cw [6];
  logic [SW-1:0] fill_s, exp_s;
  logic [15:0]   idle_inc;

  assign in_acc   = s_axis_tvalid_i && (state_q == ST_IDLE);
  assign fill_n   = fill_q + FW'(1);
  assign plen     = exp_q - FW'(HEAD_BYTES);
  assign kl_n     = kind_len(typ_q);
  assign fill_s   = SW'(fill_q);
  assign exp_s    = SW'(exp_q);
  assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;

  always_comb begin
    for (int n = 0; n < 5; n++) begin
      cw[n] = win_q[n];
    end
    cw[5] = ram_rdata;
  end

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    exp_d    = exp_q;
    idle_d   = idle_q;
    ver_d    = ver_q;
    typ_d    = typ_q;
    lo_d     = lo_q;
    crc_d    = crc_q;
    crclo_d  = crclo_q;
    ra_d     = ra_q;
    da_d     = da_q;
    src_d    = src_q;
    dv_d     = 1'b0;
    win_d    = win_q;
    lastb_d  = lastb_q;
    k_d      = k_q;
    ev_d     = ev_q;
    evk_d    = evk_q;
    ram_we    = 1'b0;
    ram_waddr = AW'(fill_q);
    ram_wdata = s_axis_tdata_i;
    ram_raddr = '0;
    out_ld   = 1'b0;
    oev_d    = ev_q;
    okind_d  = evk_q;
    obyte_d  = 8'd0;
    oidx_d   = 5'd0;
    ors_d    = 1'b0;
    olast_d  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser_i)
            CMD_BYTE: begin
              idle_d = 16'd0;
              if (fill_q == '0) begin
                if (s_axis_tdata_i == SYNC_HI) begin
                  ram_we = 1'b1;
                  fill_d = FW'(1);
                end
              end else if (fill_q == FW'(1)) begin
                exp_d = '0;
                if (s_axis_tdata_i == SYNC_LO) begin
                  ram_we = 1'b1;
                  fill_d = FW'(2);
                end else if (s_axis_tdata_i != SYNC_HI) begin
                  fill_d = '0;
                end
              end else if (fill_q >= FW'(FRAME_BYTES)) begin
                fill_d = '0;
                exp_d  = '0;
              end else begin
                ram_we = 1'b1;
                fill_d = fill_n;
                case (fill_q)
                  FW'(2): ver_d = s_axis_tdata_i;
                  FW'(3): typ_d = s_axis_tdata_i;
                  FW'(4): lo_d  = s_axis_tdata_i;
                  default: ;
                endcase
                if (fill_q == FW'(5)) begin
                  evk_d = typ_q;
                  if (ver_q != cfg_ver_q || kl_n == 5'd0) begin
                    ev_d    = EV_BAD_TYPE;
                    ra_d    = SW'(1);
                    state_d = ST_SCAN;
                  end else if ({s_axis_tdata_i, lo_q} != {11'd0, kl_n}) begin
                    ev_d    = EV_BAD_LEN;
                    ra_d    = SW'(1);
                    state_d = ST_SCAN;
                  end else begin
                    exp_d = FW'(HEAD_BYTES) + FW'(kl_n);
                  end
                end else if (exp_q != '0 && fill_n == exp_q) begin
                  ra_d    = SW'(2);
                  crc_d   = CRC_INIT;
                  state_d = ST_CRC;
                end
              end
            end
            CMD_TICK: begin
              if (fill_q == '0) begin
                idle_d = 16'd0;
              end else begin
                idle_d = idle_inc;
                if (idle_inc >= cfg_to_q) begin
                  idle_d  = 16'd0;
                  fill_d  = '0;
                  exp_d   = '0;
                  ev_d    = EV_TIMEOUT;
                  evk_d   = (fill_q >= FW'(4)) ? typ_q : 8'd0;
                  state_d = ST_EMIT;
                end
              end
            end
            CMD_OVERFLOW: begin
              idle_d  = 16'd0;
              fill_d  = '0;
              exp_d   = '0;
              ev_d    = EV_OVERFLOW;
              evk_d   = (fill_q >= FW'(4)) ? typ_q : 8'd0;
              state_d = ST_EMIT;
            end
            default: ;
          endcase
        end
      end

      ST_CRC: begin
        // Stream bytes 2 up to the end of the frame; the last two are the stored CRC.
        if (ra_q < exp_s) begin
          ram_raddr = AW'(ra_q);
          dv_d      = 1'b1;
          da_d      = ra_q;
          ra_d      = ra_q + SW'(1);
        end
        if (dv_q) begin
          if (da_q < exp_s - SW'(2)) begin
            crc_d = crc_byte(crc_q, ram_rdata);
          end else if (da_q == exp_s - SW'(2)) begin
            crclo_d = ram_rdata;
          end else begin
            dv_d = 1'b0;
            if ({ram_rdata, crclo_q} == crc_q) begin
              k_d     = '0;
              state_d = ST_PAYRD;
            end else begin
              ev_d    = EV_CRC_ERR;
              evk_d   = typ_q;
              ra_d    = SW'(1);
              state_d = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        // Sliding window of six bytes; candidate start is the oldest byte.
        ram_raddr = (ra_q < fill_s) ? AW'(ra_q) : '0;
        dv_d      = 1'b1;
        da_d      = ra_q;
        ra_d      = ra_q + SW'(1);
        if (dv_q) begin
          for (int n = 0; n < 4; n++) begin
            win_d[n] = win_q[n+1];
          end
          win_d[4] = ram_rdata;
          if (da_q == fill_s - SW'(1)) begin
            lastb_d = ram_rdata;
          end
          if (da_q >= SW'(6) && da_q < fill_s + SW'(4) && cw[0] == SYNC_HI &&
              cw[1] == SYNC_LO && (da_q >= fill_s || hdr_ok(cw[2], cw[3], cw[4], cw[5]))) begin
            src_d   = da_q - SW'(5);
            ra_d    = da_q - SW'(5);
            dv_d    = 1'b0;
            ver_d   = cw[2];
            typ_d   = cw[3];
            lo_d    = cw[4];
            exp_d   = (da_q < fill_s) ? FW'(HEAD_BYTES) + FW'({cw[5], cw[4]}) : '0;
            state_d = ST_MOVE;
          end else if (da_q == fill_s + SW'(3)) begin
            fill_d  = (lastb_q == SYNC_HI) ? FW'(1) : '0;
            exp_d   = '0;
            dv_d    = 1'b0;
            state_d = ST_EMIT;
          end
        end
      end

      ST_MOVE: begin
        // Copy the kept bytes down to the store's start, one a cycle.
        ram_raddr = AW'(ra_q);
        if (ra_q < fill_s) begin
          dv_d = 1'b1;
          da_d = ra_q;
          ra_d = ra_q + SW'(1);
        end
        if (dv_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(da_q - src_q);
          ram_wdata = ram_rdata;
          if (da_q == fill_s - SW'(1)) begin
            fill_d  = FW'(fill_s - src_q);
            dv_d    = 1'b0;
            state_d = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_ld  = 1'b1;
          ors_d   = (ev_q == EV_BAD_TYPE) || (ev_q == EV_BAD_LEN) || (ev_q == EV_CRC_ERR);
          state_d = ST_IDLE;
        end
      end

      ST_PAYRD: begin
        ram_raddr = AW'(14 + 32'(k_q));
        state_d   = ST_PAYOUT;
      end

      ST_PAYOUT: begin
        ram_raddr = AW'(14 + 32'(k_q));
        if (out_free) begin
          out_ld  = 1'b1;
          oev_d   = EV_PAYLOAD;
          okind_d = typ_q;
          obyte_d = ram_rdata;
          oidx_d  = 5'(k_q);
          olast_d = (FW'(k_q) == plen - FW'(1));
          if (olast_d) begin
            fill_d  = '0;
            exp_d   = '0;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + KW'(1);
            state_d = ST_PAYRD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      exp_q   <= '0;
      idle_q  <= 16'd0;
      dv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      exp_q   <= exp_d;
      idle_q  <= idle_d;
      dv_q    <= dv_d;
      if (out_ld) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ver_q   <= ver_d;
    typ_q   <= typ_d;
    lo_q    <= lo_d;
    crc_q   <= crc_d;
    crclo_q <= crclo_d;
    ra_q    <= ra_d;
    da_q    <= da_d;
    src_q   <= src_d;
    win_q   <= win_d;
    lastb_q <= lastb_d;
    k_q     <= k_d;
    ev_q    <= ev_d;
    evk_q   <= evk_d;
    if (out_ld) begin
      oev_q   <= oev_d;
      okind_q <= okind_d;
      obyte_q <= obyte_d;
      oidx_q  <= oidx_d;
      ors_q   <= ors_d;
      olast_q <= olast_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {2'b00, ors_q, oidx_q, obyte_q, okind_q};
  assign m_axis_tuser_o  = oev_q;
  assign m_axis_tlast_o  = olast_q;

endmodule
